FILE: src/aria_pkg.sv
// ARIA cipher core package: substitution tables, diffusion layer and shared types.
// Used by aria_dp, aria_ctrl and aria_block_cipher_modes_core.
`timescale 1ns / 1ps
`default_nettype none

package aria_pkg;

    localparam int BlkW = 128;
    localparam int RkDepth = 17;

    localparam logic [2:0] MODE_ECB_ENC = 3'd0;
    localparam logic [2:0] MODE_ECB_DEC = 3'd1;
    localparam logic [2:0] MODE_CBC_ENC = 3'd2;
    localparam logic [2:0] MODE_CBC_DEC = 3'd3;
    localparam logic [2:0] MODE_CTR     = 3'd4;

    localparam logic [3:0] REG_KEY0     = 4'd0;
    localparam logic [3:0] REG_KEY1     = 4'd1;
    localparam logic [3:0] REG_KEY2     = 4'd2;
    localparam logic [3:0] REG_KEY3     = 4'd3;
    localparam logic [3:0] REG_KEY_SIZE = 4'd4;
    localparam logic [3:0] REG_MODE     = 4'd5;
    localparam logic [3:0] REG_IV_HIGH  = 4'd6;
    localparam logic [3:0] REG_IV_LOW   = 4'd7;

    typedef enum logic [2:0] {
        OP_IDLE,
        OP_ACCEPT,
        OP_KS1,
        OP_KS2,
        OP_KS3,
        OP_KWR,
        OP_ROUND,
        OP_FINAL
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [4:0] idx;     // round key index: read in rounds, write in key sweep
        logic [4:0] ek_idx;  // expanded key selected in key sweep
        logic       diff;    // diffuse the key before storing it
        logic       first;   // first round: take the block from the input mux
        logic       kind;    // substitution layer kind
        logic       mix;     // apply diffusion after substitution
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] key_size;
        logic [2:0] mode;
    } dp_status_t;

    // Tables stored entry 0 in the top byte.
    localparam logic [2047:0] SBOX_A_TBL = {
        128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
        128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
        128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
        128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
        128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
        128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
        128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
        128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16};

    localparam logic [2047:0] SBOX_B_TBL = {
        128'he24e54fc94c24acc620d6a463c4d8bd1, 128'h5efa64cbb497be2bbc772e03d31959c1,
        128'h1d06416b55f09969ea9c18ae63dfe7bb, 128'h007366fb964c85e43a0945aa0fee10eb,
        128'h2d7ff429accfad918d78c895f92fcecd, 128'h087a88385c832a2847dbb8c793a41253,
        128'hff870e3136215848018e377432cae9b1, 128'hb7ab0cd7c4564226079860d9b6b91140,
        128'hec208cbda0c984044923f14f501f13dc, 128'hd8c09e57e3c37b653b028f3ee82592e5,
        128'h15ddfd17a9bfd49a7ec53967fe769d43, 128'ha7e1d0f568f21b347005a38ad57986a8,
        128'h30c6514b1ea627f635d26e2416825fda, 128'he675a2ef2cb21c9f5d6f800a72449b6c,
        128'h900b5b337d5a52f361a1f7b0d63f7c6d, 128'hed14e0a53d22b3f889de711aafbab581};

    function automatic logic [2047:0] invert_tbl(input logic [2047:0] tbl);
        logic [2047:0] r;
        logic [7:0] e;
        r = '0;
        for (int i = 0; i < 256; i++)
        begin
            e = tbl[2047 - 8 * i -: 8];
            r[2047 - 8 * int'(e) -: 8] = 8'(i);
        end
        return r;
    endfunction

    localparam logic [2047:0] INV_A_TBL = invert_tbl(SBOX_A_TBL);
    localparam logic [2047:0] INV_B_TBL = invert_tbl(SBOX_B_TBL);

    function automatic logic [7:0] lut(input logic [2047:0] tbl, input logic [7:0] x);
        return tbl[2047 - 8 * int'(x) -: 8];
    endfunction

    function automatic logic [127:0] diffuse(input logic [127:0] v);
        logic [7:0] x [16];
        logic [7:0] y [16];
        logic [127:0] r;
        for (int i = 0; i < 16; i++)
        begin
            x[i] = v[127 - 8 * i -: 8];
        end
        y[0]  = x[3] ^ x[4] ^ x[6] ^ x[8] ^ x[9] ^ x[13] ^ x[14];
        y[1]  = x[2] ^ x[5] ^ x[7] ^ x[8] ^ x[9] ^ x[12] ^ x[15];
        y[2]  = x[1] ^ x[4] ^ x[6] ^ x[10] ^ x[11] ^ x[12] ^ x[15];
        y[3]  = x[0] ^ x[5] ^ x[7] ^ x[10] ^ x[11] ^ x[13] ^ x[14];
        y[4]  = x[0] ^ x[2] ^ x[5] ^ x[8] ^ x[11] ^ x[14] ^ x[15];
        y[5]  = x[1] ^ x[3] ^ x[4] ^ x[9] ^ x[10] ^ x[14] ^ x[15];
        y[6]  = x[0] ^ x[2] ^ x[7] ^ x[9] ^ x[10] ^ x[12] ^ x[13];
        y[7]  = x[1] ^ x[3] ^ x[6] ^ x[8] ^ x[11] ^ x[12] ^ x[13];
        y[8]  = x[0] ^ x[1] ^ x[4] ^ x[7] ^ x[10] ^ x[13] ^ x[15];
        y[9]  = x[0] ^ x[1] ^ x[5] ^ x[6] ^ x[11] ^ x[12] ^ x[14];
        y[10] = x[2] ^ x[3] ^ x[5] ^ x[6] ^ x[8] ^ x[13] ^ x[15];
        y[11] = x[2] ^ x[3] ^ x[4] ^ x[7] ^ x[9] ^ x[12] ^ x[14];
        y[12] = x[1] ^ x[2] ^ x[6] ^ x[7] ^ x[9] ^ x[11] ^ x[12];
        y[13] = x[0] ^ x[3] ^ x[6] ^ x[7] ^ x[8] ^ x[10] ^ x[13];
        y[14] = x[0] ^ x[3] ^ x[4] ^ x[5] ^ x[9] ^ x[11] ^ x[14];
        y[15] = x[1] ^ x[2] ^ x[4] ^ x[5] ^ x[8] ^ x[10] ^ x[15];
        for (int i = 0; i < 16; i++)
        begin
            r[127 - 8 * i -: 8] = y[i];
        end
        return r;
    endfunction

    // Kind 0: SB1, SB2, inverse SB1, inverse SB2 per lane; kind 1 swaps the pairs.
    function automatic logic [127:0] sub_layer(input logic [127:0] v, input logic kind,
                                               input logic mix);
        logic [127:0] t;
        logic [1:0] sel;
        logic [7:0] b;
        for (int i = 0; i < 16; i++)
        begin
            sel = 2'(i) + {kind, 1'b0};
            b = v[127 - 8 * i -: 8];
            unique case (sel)
                2'd0:    t[127 - 8 * i -: 8] = lut(SBOX_A_TBL, b);
                2'd1:    t[127 - 8 * i -: 8] = lut(SBOX_B_TBL, b);
                2'd2:    t[127 - 8 * i -: 8] = lut(INV_A_TBL, b);
                default: t[127 - 8 * i -: 8] = lut(INV_B_TBL, b);
            endcase
        end
        return mix ? diffuse(t) : t;
    endfunction

    function automatic logic [127:0] ror128(input logic [127:0] v, input int n);
        return (v >> n) | (v << (128 - n));
    endfunction

    function automatic logic [127:0] sched_const(input logic [2:0] s);
        logic [127:0] c;
        unique case (s)
            3'd0, 3'd3: c = 128'h517cc1b727220a94fe13abe8fa9a6ee0;
            3'd1, 3'd4: c = 128'h6db14acc9e21c820ff28b1d5ef5de2b0;
            default:    c = 128'hdb92371d2126e9700324977504e8c90e;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: src/aria_block_cipher_modes_core.sv
// ARIA block cipher core, ECB/CBC/CTR, top level.
// Each request runs the rounds; a final step, held by m_axis_tready, loads the output.
// A start_message request first runs the key schedule and key store sweep. One shared
// round unit takes one request at a time; s_axis_tready waits for the result load.
// Reset (rst_n, async, low): clears configuration, chain value and control; round
// keys hold no value until the first start_message request.
`timescale 1ns / 1ps
`default_nettype none

module aria_block_cipher_modes_core
    import aria_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [3:0]   cfg_addr,
    input  wire logic [63:0]  cfg_wdata,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [135:0] s_axis_tdata,  // zero pad, byte_count, data_hi, data_lo
    input  wire logic         s_axis_tuser,  // start_message
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [127:0]      m_axis_tdata   // out_hi, out_lo
);

    dp_cmd_t    cmd;
    dp_status_t status;

    aria_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_start  (s_axis_tuser),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    aria_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_axis_tdata),
        .in_start  (s_axis_tuser),
        .cmd       (cmd),
        .status    (status),
        .out_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire

FILE: src/aria_dp.sv
// ARIA datapath: configuration registers, key schedule, round key store and round unit.
// Depends on aria_pkg; driven by commands from aria_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module aria_dp
    import aria_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [3:0]   cfg_addr,
    input  wire logic [63:0]  cfg_wdata,
    input  wire logic [135:0] in_data,   // zero pad, byte_count, data_hi, data_lo
    input  wire logic         in_start,
    input  wire dp_cmd_t      cmd,
    output dp_status_t        status,
    output logic [127:0]      out_data   // out_hi, out_lo
);

    logic [63:0]  key0_reg, key1_reg, key2_reg, key3_reg, ivh_reg, ivl_reg;
    logic [1:0]   ksize_reg;
    logic [2:0]   mode_reg;
    logic [127:0] w1_reg, w2_reg, w3_reg;
    logic [127:0] x_reg, d_reg, chain_reg, out_reg;
    logic [4:0]   cnt_reg;
    logic [127:0] rk_mem [RkDepth];

    logic [1:0]   sz;
    logic [127:0] kl, kr, w_a, w_b, ek, rk_rd, cin, res, unit_in, unit_out, mask;
    logic         unit_kind, unit_mix;
    logic [127:0] w_arr [4];

    assign status.key_size = ksize_reg;
    assign status.mode = mode_reg;
    assign out_data = {out_reg[63:0], out_reg[127:64]};

    assign sz = (ksize_reg == 2'd3) ? 2'd2 : ksize_reg;
    assign kl = {key0_reg, key1_reg};
    assign kr = {(sz != 2'd0) ? key2_reg : 64'd0, (sz == 2'd2) ? key3_reg : 64'd0};
    assign rk_rd = rk_mem[cmd.idx];

    always_comb
    begin
        w_arr[0] = kl;
        w_arr[1] = w1_reg;
        w_arr[2] = w2_reg;
        w_arr[3] = w3_reg;
        w_a = w_arr[cmd.ek_idx[1:0]];
        w_b = w_arr[cmd.ek_idx[1:0] + 2'd1];
        unique case (cmd.ek_idx[4:2])
            3'd0:    ek = w_a ^ ror128(w_b, 19);
            3'd1:    ek = w_a ^ ror128(w_b, 31);
            3'd2:    ek = w_a ^ ror128(w_b, 67);
            3'd3:    ek = w_a ^ ror128(w_b, 97);
            default: ek = w_a ^ ror128(w_b, 109);
        endcase
    end

    always_comb
    begin
        unique case (mode_reg)
            MODE_CBC_ENC: cin = d_reg ^ chain_reg;
            MODE_CTR:     cin = chain_reg;
            default:      cin = d_reg;
        endcase
        for (int i = 0; i < 16; i++)
        begin
            mask[127 - 8 * i -: 8] = (5'(i) < cnt_reg) ? 8'hff : 8'h00;
        end
        unique case (cmd.op)
            OP_KS1:
            begin
                unit_in = kl ^ sched_const({1'b0, sz});
                unit_kind = 1'b0;
                unit_mix = 1'b1;
            end
            OP_KS2:
            begin
                unit_in = w1_reg ^ sched_const({1'b0, sz} + 3'd1);
                unit_kind = 1'b1;
                unit_mix = 1'b1;
            end
            OP_KS3:
            begin
                unit_in = w2_reg ^ sched_const({1'b0, sz} + 3'd2);
                unit_kind = 1'b0;
                unit_mix = 1'b1;
            end
            default:
            begin
                unit_in = (cmd.first ? cin : x_reg) ^ rk_rd;
                unit_kind = cmd.kind;
                unit_mix = cmd.mix;
            end
        endcase
        unit_out = sub_layer(unit_in, unit_kind, unit_mix);
        res = x_reg ^ rk_rd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key0_reg <= '0;
            key1_reg <= '0;
            key2_reg <= '0;
            key3_reg <= '0;
            ksize_reg <= '0;
            mode_reg <= '0;
            ivh_reg <= '0;
            ivl_reg <= '0;
            chain_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_KEY0:     key0_reg <= cfg_wdata;
                    REG_KEY1:     key1_reg <= cfg_wdata;
                    REG_KEY2:     key2_reg <= cfg_wdata;
                    REG_KEY3:     key3_reg <= cfg_wdata;
                    REG_KEY_SIZE: ksize_reg <= cfg_wdata[1:0];
                    REG_MODE:     mode_reg <= cfg_wdata[2:0];
                    REG_IV_HIGH:  ivh_reg <= cfg_wdata;
                    REG_IV_LOW:   ivl_reg <= cfg_wdata;
                    default:      ;
                endcase
            end
            if (cmd.op == OP_ACCEPT && in_start)
            begin
                chain_reg <= {ivh_reg, ivl_reg};
            end
            else if (cmd.op == OP_FINAL)
            begin
                unique case (mode_reg)
                    MODE_CBC_ENC: chain_reg <= res;
                    MODE_CBC_DEC: chain_reg <= d_reg;
                    MODE_CTR:     chain_reg <= chain_reg + 128'd1;
                    default:      ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_ACCEPT:
            begin
                d_reg <= {in_data[63:0], in_data[127:64]};
                cnt_reg <= in_data[132:128];
            end
            OP_KS1: w1_reg <= unit_out ^ kr;
            OP_KS2: w2_reg <= unit_out ^ kl;
            OP_KS3: w3_reg <= unit_out ^ w1_reg;
            OP_KWR: rk_mem[cmd.idx] <= cmd.diff ? diffuse(ek) : ek;
            OP_ROUND: x_reg <= unit_out;
            OP_FINAL:
            begin
                unique case (mode_reg)
                    MODE_CBC_DEC: out_reg <= res ^ chain_reg;
                    MODE_CTR:     out_reg <= (res ^ d_reg) & mask;
                    default:      out_reg <= res;
                endcase
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

FILE: src/aria_ctrl.sv
// ARIA controller: sequences key derivation, key store sweep, rounds and result handoff.
// Depends on aria_pkg; commands aria_dp.
`timescale 1ns / 1ps
`default_nettype none

module aria_ctrl
    import aria_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       in_start,
    output logic            in_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KS1,
        ST_KS2,
        ST_KS3,
        ST_KWR,
        ST_ROUND,
        ST_FINAL
    } state_t;

    state_t     state_reg;
    logic [4:0] rc_reg;      // latched round count: 12, 14 or 16
    logic [4:0] cnt_reg;     // round or key sweep index
    logic       enc_reg;
    logic       out_valid_reg;

    logic       accept, last, load_out;
    logic [1:0] sz;
    logic [4:0] rc_new;

    assign in_ready = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign accept = in_valid && in_ready;
    assign last = (cnt_reg == rc_reg - 5'd1);
    assign load_out = (state_reg == ST_FINAL) && (!out_valid_reg || out_ready);
    assign sz = (status.key_size == 2'd3) ? 2'd2 : status.key_size;
    assign rc_new = 5'd12 + {2'd0, sz, 1'b0};

    always_comb
    begin
        cmd = '0;
        cmd.op = OP_IDLE;
        unique case (state_reg)
            ST_IDLE:  cmd.op = accept ? OP_ACCEPT : OP_IDLE;
            ST_KS1:   cmd.op = OP_KS1;
            ST_KS2:   cmd.op = OP_KS2;
            ST_KS3:   cmd.op = OP_KS3;
            ST_KWR:
            begin
                cmd.op = OP_KWR;
                cmd.idx = cnt_reg;
                if (enc_reg)
                    cmd.ek_idx = cnt_reg;
                else if (cnt_reg == 5'd0)
                    cmd.ek_idx = rc_reg;
                else if (cnt_reg == rc_reg)
                    cmd.ek_idx = 5'd0;
                else
                    cmd.ek_idx = rc_reg - cnt_reg;
                cmd.diff = !enc_reg && (cnt_reg != 5'd0) && (cnt_reg != rc_reg);
            end
            ST_ROUND:
            begin
                cmd.op = OP_ROUND;
                cmd.idx = cnt_reg;
                cmd.first = (cnt_reg == 5'd0);
                cmd.kind = last ? 1'b1 : cnt_reg[0];
                cmd.mix = !last;
            end
            ST_FINAL:
            begin
                cmd.op = load_out ? OP_FINAL : OP_IDLE;
                cmd.idx = rc_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rc_reg <= 5'd12;
            cnt_reg <= '0;
            enc_reg <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    cnt_reg <= '0;
                    if (accept)
                    begin
                        if (in_start)
                        begin
                            rc_reg <= rc_new;
                            enc_reg <= !(status.mode == MODE_ECB_DEC ||
                                         status.mode == MODE_CBC_DEC);
                            state_reg <= ST_KS1;
                        end
                        else
                            state_reg <= ST_ROUND;
                    end
                end
                ST_KS1: state_reg <= ST_KS2;
                ST_KS2: state_reg <= ST_KS3;
                ST_KS3: state_reg <= ST_KWR;
                ST_KWR:
                begin
                    // advance the store sweep, then start the rounds
                    if (cnt_reg == rc_reg)
                    begin
                        cnt_reg <= '0;
                        state_reg <= ST_ROUND;
                    end
                    else
                        cnt_reg <= cnt_reg + 5'd1;
                end
                ST_ROUND:
                begin
                    if (last)
                        state_reg <= ST_FINAL;
                    else
                        cnt_reg <= cnt_reg + 5'd1;
                end
                ST_FINAL:
                begin
                    // hold the result until the output register frees up
                    if (load_out)
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_rc_legal: assert property (@(posedge clk) disable iff (!rst_n)
        rc_reg == 5'd12 || rc_reg == 5'd14 || rc_reg == 5'd16)
        else $error("round count out of range");

    a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ROUND |-> cnt_reg < rc_reg)
        else $error("round index past last round");

    a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_KWR |-> cnt_reg <= rc_reg)
        else $error("key store index past last key");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINAL))
        else $error("result raised outside final step");

endmodule

`default_nettype wire
